FILE: rtl/core/eehc_pkg.sv
// Shared types, sizes and helper functions for the error event hash counter.
`timescale 1ns / 1ps
`default_nettype none

package eehc_pkg;

    // Table geometry.
    localparam int TableDepth = 1024;
    localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
    localparam bit DepthPow2  = ((TableDepth & (TableDepth - 1)) == 0);

    // Field widths fixed by the interface.
    localparam int WordW = 32;
    localparam int LineW = 16;
    localparam int SlotW = 10;

    // Start-index remainder for a depth that is not a power of two. The quotient is
    // (hash * ModMagic) >> ModShift, which is exact for every 32-bit hash word; the
    // remainder is then the hash minus quotient times depth.
    localparam int ModShift = WordW + IdxW;
    localparam int MagicW   = WordW + 1;
    localparam int MulW     = WordW + MagicW;
    localparam int QuotW    = MulW - ModShift;
    localparam logic [MagicW-1:0] ModMagic =
        MagicW'(((64'd1 << ModShift) + 64'(TableDepth) - 64'd1) / 64'(TableDepth));

    localparam logic [WordW-1:0] CountMax = '1;

    typedef logic [IdxW-1:0] t_idx;

    // One table slot; a zero message marks the slot as empty.
    typedef struct packed {
        logic [WordW-1:0] message;
        logic [WordW-1:0] site;
        logic [LineW-1:0] line;
        logic [WordW-1:0] first_param;
        logic [WordW-1:0] second_param;
        logic [WordW-1:0] count;
        logic [WordW-1:0] last_time;
    } t_entry;

    // Memory request from the sequencer to the table.
    typedef struct packed {
        logic   rd_en;
        t_idx   rd_addr;
        logic   wr_en;
        t_idx   wr_addr;
        t_entry wr_data;
    } t_mem_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_REM,
        ST_LOOKUP,
        ST_CHECK,
        ST_PUSH
    } t_state;

    typedef enum logic [2:0] {
        STATUS_INSERTED = 3'd0,
        STATUS_COUNTED  = 3'd1,
        STATUS_REJECTED = 3'd2,
        STATUS_FULL     = 3'd3,
        STATUS_CLEARED  = 3'd4
    } t_status;

    localparam logic ACTION_RECORD = 1'b0;
    localparam logic ACTION_CLEAR  = 1'b1;

    // Low bits of a table index as reported on the result.
    function automatic logic [SlotW-1:0] slot_of(t_idx idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[SlotW-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/eehc_table.sv
// Entry memory of the hash table: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module eehc_table (
    input  wire logic              i_clk,
    input  wire eehc_pkg::t_mem_req i_req,
    output eehc_pkg::t_entry       o_rd_data
);

    eehc_pkg::t_entry r_mem [eehc_pkg::TableDepth];
    eehc_pkg::t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Registered read port, loaded when rd_en is set.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/core/error_event_hash_counter.sv
// Error event counter over an open-addressed, linearly probed hash table.
// Record request: after accept the start slot is read (ST_LOOKUP), checked (ST_CHECK, once per
//   probe) and the result is pushed to the output register (ST_PUSH); the probe loop reads
//   one slot a cycle through the single table read port. A non power of two depth adds
//   ST_MOD and ST_REM for the start-index remainder (reciprocal multiply, then multiply back).
// Clear request: a pass writes every slot empty, then the result. A new request is taken only
// once the last result is loaded. After reset the same clearing pass runs with o_stall high.
`timescale 1ns / 1ps
`default_nettype none

module error_event_hash_counter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration.
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data,
    // Request channel.
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_action,
    input  wire logic [31:0] i_hash_word,
    input  wire logic [31:0] i_message_id,
    input  wire logic [31:0] i_site_id,
    input  wire logic [15:0] i_line_number,
    input  wire logic [31:0] i_first_param,
    input  wire logic [31:0] i_second_param,
    input  wire logic [31:0] i_timestamp,
    // Result channel.
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [9:0]       o_slot,
    output logic [31:0]      o_hit_count
);

    localparam eehc_pkg::t_idx IdxLast = eehc_pkg::IdxW'(eehc_pkg::TableDepth - 1);

    // Sequencer state.
    eehc_pkg::t_state r_state, n_state;
    eehc_pkg::t_idx   r_idx, n_idx;
    eehc_pkg::t_idx   r_probe, n_probe;
    logic             r_clr_reply, n_clr_reply;
    logic             r_enabled;

    // Latched request.
    logic [31:0] r_req_msg, n_req_msg;
    logic [31:0] r_req_site, n_req_site;
    logic [15:0] r_req_line, n_req_line;
    logic [31:0] r_req_p0, n_req_p0;
    logic [31:0] r_req_p1, n_req_p1;
    logic [31:0] r_req_now, n_req_now;
    logic [31:0] r_hash, n_hash;
    logic [eehc_pkg::QuotW-1:0] r_quot, n_quot;

    // Pending result.
    eehc_pkg::t_status r_res_status, n_res_status;
    eehc_pkg::t_idx    r_res_slot, n_res_slot;
    logic [31:0]       r_res_count, n_res_count;

    // Output register.
    logic              r_o_valid;
    eehc_pkg::t_status r_o_status;
    logic [9:0]        r_o_slot;
    logic [31:0]       r_o_count;

    // Table interface.
    eehc_pkg::t_mem_req mem_req;
    eehc_pkg::t_entry   rd;
    eehc_pkg::t_entry   upd_entry;
    eehc_pkg::t_entry   new_entry;

    logic           in_accept;
    logic           push_go;
    logic           req_reject;
    logic           slot_empty;
    logic           slot_match;
    logic           probe_last;
    logic [31:0]    count_inc;
    eehc_pkg::t_idx idx_next;

    // Start-index remainder datapath.
    logic [eehc_pkg::MulW-1:0] quot_prod;
    logic [31:0]               quot_back;
    logic [31:0]               hash_rem;

    eehc_table u_table (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd)
    );

    // Handshake and probe decisions.
    assign o_stall    = (r_state != eehc_pkg::ST_IDLE);
    assign in_accept  = i_valid && !o_stall;
    assign push_go    = (r_state == eehc_pkg::ST_PUSH) && (!r_o_valid || !i_stall);
    assign req_reject = !r_enabled || (i_message_id == '0);
    assign slot_empty = (rd.message == '0);
    assign slot_match = (rd.message == r_req_msg) && (rd.site == r_req_site) &&
                        (rd.line == r_req_line);
    assign probe_last = (r_probe == IdxLast);
    assign count_inc  = (rd.count == eehc_pkg::CountMax) ? rd.count : rd.count + 32'd1;
    assign idx_next   = (r_idx == IdxLast) ? '0 : r_idx + eehc_pkg::IdxW'(1);

    // Quotient by reciprocal multiplication, then the remainder from the registered quotient.
    assign quot_prod = eehc_pkg::MulW'(r_hash) * eehc_pkg::MulW'(eehc_pkg::ModMagic);
    assign quot_back = eehc_pkg::WordW'(r_quot) * eehc_pkg::WordW'(eehc_pkg::TableDepth);
    assign hash_rem  = r_hash - quot_back;

    // Entries written back on a hit or an insert.
    always_comb begin
        upd_entry           = rd;
        upd_entry.count     = count_inc;
        upd_entry.last_time = r_req_now;

        new_entry.message      = r_req_msg;
        new_entry.site         = r_req_site;
        new_entry.line         = r_req_line;
        new_entry.first_param  = r_req_p0;
        new_entry.second_param = r_req_p1;
        new_entry.count        = 32'd1;
        new_entry.last_time    = r_req_now;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            eehc_pkg::ST_CLEAR: begin
                if (r_idx == IdxLast) begin
                    n_state = r_clr_reply ? eehc_pkg::ST_PUSH : eehc_pkg::ST_IDLE;
                end
            end
            eehc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_action == eehc_pkg::ACTION_CLEAR) begin
                        n_state = eehc_pkg::ST_CLEAR;
                    end else if (req_reject) begin
                        n_state = eehc_pkg::ST_PUSH;
                    end else if (eehc_pkg::DepthPow2) begin
                        n_state = eehc_pkg::ST_LOOKUP;
                    end else begin
                        n_state = eehc_pkg::ST_MOD;
                    end
                end
            end
            eehc_pkg::ST_MOD: begin
                n_state = eehc_pkg::ST_REM;
            end
            eehc_pkg::ST_REM: begin
                n_state = eehc_pkg::ST_LOOKUP;
            end
            eehc_pkg::ST_LOOKUP: begin
                n_state = eehc_pkg::ST_CHECK;
            end
            eehc_pkg::ST_CHECK: begin
                if (slot_empty || slot_match || probe_last) begin
                    n_state = eehc_pkg::ST_PUSH;
                end
            end
            eehc_pkg::ST_PUSH: begin
                if (push_go) begin
                    n_state = eehc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = eehc_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory requests and datapath updates for each state.
    always_comb begin
        mem_req      = '0;
        n_idx        = r_idx;
        n_probe      = r_probe;
        n_clr_reply  = r_clr_reply;
        n_req_msg    = r_req_msg;
        n_req_site   = r_req_site;
        n_req_line   = r_req_line;
        n_req_p0     = r_req_p0;
        n_req_p1     = r_req_p1;
        n_req_now    = r_req_now;
        n_hash       = r_hash;
        n_quot       = r_quot;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_count  = r_res_count;
        case (r_state)
            eehc_pkg::ST_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_idx;
                mem_req.wr_data = '0;
                n_idx           = idx_next;
                if (r_idx == IdxLast) begin
                    n_clr_reply = 1'b0;
                end
            end
            eehc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_req_msg   = i_message_id;
                    n_req_site  = i_site_id;
                    n_req_line  = i_line_number;
                    n_req_p0    = i_first_param;
                    n_req_p1    = i_second_param;
                    n_req_now   = i_timestamp;
                    n_hash      = i_hash_word;
                    n_probe     = '0;
                    n_res_slot  = '0;
                    n_res_count = '0;
                    n_idx       = eehc_pkg::DepthPow2 ?
                                  i_hash_word[eehc_pkg::IdxW-1:0] : '0;
                    if (i_action == eehc_pkg::ACTION_CLEAR) begin
                        n_idx        = '0;
                        n_clr_reply  = 1'b1;
                        n_res_status = eehc_pkg::STATUS_CLEARED;
                    end else if (req_reject) begin
                        n_res_status = eehc_pkg::STATUS_REJECTED;
                    end
                end
            end
            eehc_pkg::ST_MOD: begin
                n_quot = quot_prod[eehc_pkg::MulW-1:eehc_pkg::ModShift];
            end
            eehc_pkg::ST_REM: begin
                n_idx = hash_rem[eehc_pkg::IdxW-1:0];
            end
            eehc_pkg::ST_LOOKUP: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_idx;
            end
            eehc_pkg::ST_CHECK: begin
                if (slot_empty) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_idx;
                    mem_req.wr_data = new_entry;
                    n_res_status    = eehc_pkg::STATUS_INSERTED;
                    n_res_slot      = r_idx;
                    n_res_count     = 32'd1;
                end else if (slot_match) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_idx;
                    mem_req.wr_data = upd_entry;
                    n_res_status    = eehc_pkg::STATUS_COUNTED;
                    n_res_slot      = r_idx;
                    n_res_count     = count_inc;
                end else if (probe_last) begin
                    n_res_status = eehc_pkg::STATUS_FULL;
                end else begin
                    // Probe the following slot in the next cycle.
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_next;
                    n_idx           = idx_next;
                    n_probe         = r_probe + eehc_pkg::IdxW'(1);
                end
            end
            eehc_pkg::ST_PUSH: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= eehc_pkg::ST_CLEAR;
            r_idx       <= '0;
            r_probe     <= '0;
            r_clr_reply <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_probe     <= n_probe;
            r_clr_reply <= n_clr_reply;
        end
    end

    // Enable register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_enabled <= i_cfg_wr_data;
        end
    end

    // Request and pending result payload.
    always_ff @(posedge i_clk) begin
        r_req_msg    <= n_req_msg;
        r_req_site   <= n_req_site;
        r_req_line   <= n_req_line;
        r_req_p0     <= n_req_p0;
        r_req_p1     <= n_req_p1;
        r_req_now    <= n_req_now;
        r_hash       <= n_hash;
        r_quot       <= n_quot;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_count  <= n_res_count;
    end

    // Output register: loads when empty or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (push_go) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_go) begin
            r_o_status <= r_res_status;
            r_o_slot   <= eehc_pkg::slot_of(r_res_slot);
            r_o_count  <= r_res_count;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_slot      = r_o_slot;
    assign o_hit_count = r_o_count;

endmodule

`default_nettype wire

FILE: test/tb_error_event_hash_counter.sv
// Self-checking testbench for the error event hash counter.
`timescale 1ns / 1ps

module tb_error_event_hash_counter;

    // Key used by the directed requests.
    localparam logic [31:0] DIRECTED_MSG  = 32'h0000_0A01;
    localparam logic [31:0] DIRECTED_SITE = 32'h0000_5100;
    localparam logic [15:0] DIRECTED_LINE = 16'd42;

    // Cycles allowed after the last result before the block counts as idle.
    localparam int SETTLE_CYCLES = 16;

    // Long receiver hold that backs the block up into its request port.
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_INTERVAL = 800;

    typedef struct {
        logic        action;
        logic [31:0] hash_word;
        logic [31:0] message_id;
        logic [31:0] site_id;
        logic [15:0] line_number;
        logic [31:0] first_param;
        logic [31:0] second_param;
        logic [31:0] timestamp;
    } t_event_request;

    typedef struct {
        eehc_pkg::t_status          status;
        logic [eehc_pkg::SlotW-1:0] slot;
        logic [eehc_pkg::WordW-1:0] hit_count;
    } t_event_result;

    typedef struct {
        logic [31:0] message;
        logic [31:0] site;
        logic [15:0] line;
        int          hash_lo;
    } t_error_key;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_wr_en    = 1'b0;
    logic        i_cfg_wr_data  = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_stall;
    logic        i_action       = 1'b0;
    logic [31:0] i_hash_word    = '0;
    logic [31:0] i_message_id   = '0;
    logic [31:0] i_site_id      = '0;
    logic [15:0] i_line_number  = '0;
    logic [31:0] i_first_param  = '0;
    logic [31:0] i_second_param = '0;
    logic [31:0] i_timestamp    = '0;
    logic        o_valid;
    logic        i_stall        = 1'b0;
    logic [2:0]  o_status;
    logic [9:0]  o_slot;
    logic [31:0] o_hit_count;

    // Shadow of the block's table and enable register.
    eehc_pkg::t_entry event_table [eehc_pkg::TableDepth];
    logic             recording_enabled = 1'b1;

    t_event_request pending_requests[$];
    t_event_result  expected_results[$];
    t_event_request current_req;

    int requests_issued   = 0;
    int requests_accepted = 0;
    int results_seen      = 0;
    int error_count       = 0;
    int gap_left          = 0;
    int stall_left        = 0;
    int hold_left         = 0;
    int next_hold_at      = 150;

    error_event_hash_counter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_hash_word    (i_hash_word),
        .i_message_id   (i_message_id),
        .i_site_id      (i_site_id),
        .i_line_number  (i_line_number),
        .i_first_param  (i_first_param),
        .i_second_param (i_second_param),
        .i_timestamp    (i_timestamp),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_hit_count    (o_hit_count)
    );

    always #2 i_clk = ~i_clk;

    // Applies one request to the shadow table and returns the result it should give.
    function automatic t_event_result count_event(input t_event_request req);
        t_event_result res;
        int            idx;
        int            probe;
        res.status    = eehc_pkg::STATUS_REJECTED;
        res.slot      = '0;
        res.hit_count = '0;
        if (req.action == eehc_pkg::ACTION_CLEAR) begin
            foreach (event_table[i]) begin
                event_table[i] = '0;
            end
            res.status = eehc_pkg::STATUS_CLEARED;
            return res;
        end
        if (!recording_enabled || req.message_id == '0) begin
            return res;
        end
        idx = int'(req.hash_word % eehc_pkg::TableDepth);
        for (probe = 0; probe < eehc_pkg::TableDepth; probe++) begin
            if (event_table[idx].message == '0) begin
                event_table[idx].message      = req.message_id;
                event_table[idx].site         = req.site_id;
                event_table[idx].line         = req.line_number;
                event_table[idx].first_param  = req.first_param;
                event_table[idx].second_param = req.second_param;
                event_table[idx].count        = 1;
                event_table[idx].last_time    = req.timestamp;
                res.status    = eehc_pkg::STATUS_INSERTED;
                res.slot      = eehc_pkg::SlotW'(idx);
                res.hit_count = 1;
                return res;
            end
            if (event_table[idx].message == req.message_id &&
                    event_table[idx].site == req.site_id &&
                    event_table[idx].line == req.line_number) begin
                // The count sticks at its maximum while the time still moves.
                if (event_table[idx].count != eehc_pkg::CountMax) begin
                    event_table[idx].count = event_table[idx].count + 1;
                end
                event_table[idx].last_time = req.timestamp;
                res.status    = eehc_pkg::STATUS_COUNTED;
                res.slot      = eehc_pkg::SlotW'(idx);
                res.hit_count = event_table[idx].count;
                return res;
            end
            idx = (idx + 1) % eehc_pkg::TableDepth;
        end
        res.status = eehc_pkg::STATUS_FULL;
        return res;
    endfunction

    function automatic t_event_request make_record(input logic [31:0] hash_word,
                                                   input logic [31:0] message_id,
                                                   input logic [31:0] site_id,
                                                   input logic [15:0] line_number);
        t_event_request req;
        req.action       = eehc_pkg::ACTION_RECORD;
        req.hash_word    = hash_word;
        req.message_id   = message_id;
        req.site_id      = site_id;
        req.line_number  = line_number;
        req.first_param  = $urandom();
        req.second_param = $urandom();
        req.timestamp    = $urandom();
        return req;
    endfunction

    // A clear request carries random payload that the block must ignore.
    function automatic t_event_request make_clear();
        t_event_request req;
        req        = make_record($urandom(), $urandom(), $urandom(), 16'($urandom()));
        req.action = eehc_pkg::ACTION_CLEAR;
        return req;
    endfunction

    // Hash word with random upper bits that still starts probing at the given slot.
    function automatic logic [31:0] hash_at(input int slot_index);
        return ($urandom() & ~32'(eehc_pkg::TableDepth - 1)) | 32'(slot_index);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void report_error(input string text);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t: %s", $realtime, text);
        end
    endfunction

    task automatic queue_request(input t_event_request req);
        pending_requests.push_back(req);
        requests_issued++;
    endtask

    // Waits until every queued request has produced its result, then lets the block settle.
    task automatic drain_results();
        @(posedge i_clk);
        while (results_seen < requests_issued) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enabled(input logic value);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        recording_enabled = value;
    endtask

    // Mostly repeats of a small key pool clustered around one start slot, so that
    // probe chains, near misses and rising counts are common; the rest is noise.
    task automatic queue_random_phase(input int item_total);
        logic [31:0]    msg_pool  [6];
        logic [31:0]    site_pool [3];
        logic [15:0]    line_pool [3];
        t_error_key     key_pool  [24];
        t_error_key     key;
        t_event_request req;
        int             cluster;
        int             n;
        int             r;
        cluster = ($urandom_range(0, 2) == 0) ? eehc_pkg::TableDepth - 5 :
                  $urandom_range(0, eehc_pkg::TableDepth - 1);
        foreach (msg_pool[i]) begin
            msg_pool[i] = $urandom() | 32'h1;
        end
        foreach (site_pool[i]) begin
            site_pool[i] = $urandom();
        end
        foreach (line_pool[i]) begin
            line_pool[i] = 16'($urandom());
        end
        foreach (key_pool[i]) begin
            key_pool[i].message = msg_pool[$urandom_range(0, 5)];
            key_pool[i].site    = site_pool[$urandom_range(0, 2)];
            key_pool[i].line    = line_pool[$urandom_range(0, 2)];
            key_pool[i].hash_lo = (cluster + $urandom_range(0, 7)) % eehc_pkg::TableDepth;
        end
        for (n = 0; n < item_total; n++) begin
            r   = $urandom_range(0, 99);
            key = key_pool[$urandom_range(0, 23)];
            if (r < 72) begin
                req = make_record(hash_at(key.hash_lo), key.message, key.site, key.line);
            end else if (r < 88) begin
                req = make_record($urandom(), $urandom(), $urandom(), 16'($urandom()));
            end else if (r < 94) begin
                req = make_record($urandom(), '0, $urandom(), 16'($urandom()));
            end else if (r < 97) begin
                req = make_record(hash_at(key.hash_lo), key.message, $urandom(), key.line);
            end else begin
                req = make_clear();
            end
            queue_request(req);
        end
    endtask

    // Request driver: holds a stalled request, otherwise waits out its gap and sends the next.
    always @(posedge i_clk) begin : request_driver
        logic next_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            next_valid = i_valid;
            if (i_valid && !o_stall) begin
                expected_results.push_back(count_event(current_req));
                requests_accepted++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_requests.size() != 0) begin
                    current_req     = pending_requests.pop_front();
                    i_action       <= current_req.action;
                    i_hash_word    <= current_req.hash_word;
                    i_message_id   <= current_req.message_id;
                    i_site_id      <= current_req.site_id;
                    i_line_number  <= current_req.line_number;
                    i_first_param  <= current_req.first_param;
                    i_second_param <= current_req.second_param;
                    i_timestamp    <= current_req.timestamp;
                    next_valid      = 1'b1;
                    gap_left        = pick_gap();
                end
            end
            i_valid <= next_valid;
        end
    end

    // Every so many accepted requests the receiver stops taking results for a long stretch.
    always @(posedge i_clk) begin : receiver_hold
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (requests_accepted >= next_hold_at) begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + HOLD_INTERVAL;
        end
    end

    // Result monitor: checks each accepted result against the oldest expectation.
    always @(posedge i_clk) begin : result_monitor
        t_event_result want;
        logic          next_stall;
        int            r;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_error($sformatf("unexpected result: status %0d slot %0d count %0d",
                                       o_status, o_slot, o_hit_count));
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status || o_slot !== want.slot ||
                        o_hit_count !== want.hit_count) begin
                    report_error($sformatf(
                        "result mismatch: status %0d/%0d slot %0d/%0d count %0d/%0d (exp/got)",
                        want.status, o_status, want.slot, o_slot, want.hit_count,
                        o_hit_count));
                end
            end
        end
        if (hold_left != 0) begin
            next_stall = 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            next_stall = 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                next_stall = 1'b0;
            end else if (r < 96) begin
                stall_left = $urandom_range(0, 2);
                next_stall = 1'b1;
            end else begin
                stall_left = $urandom_range(10, 50);
                next_stall = 1'b1;
            end
        end
        i_stall <= next_stall;
    end

    initial begin : stimulus
        t_event_request req;
        t_error_key     deep_key;
        int             k;

        // The block comes out of reset with an empty table.
        foreach (event_table[i]) begin
            event_table[i] = '0;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Insert, recount, and two near misses that share the message but not site or line.
        queue_request(make_record(32'h0, DIRECTED_MSG, DIRECTED_SITE, DIRECTED_LINE));
        queue_request(make_record(32'h0, DIRECTED_MSG, DIRECTED_SITE, DIRECTED_LINE));
        queue_request(make_record(32'h0, DIRECTED_MSG, DIRECTED_SITE + 32'd1, DIRECTED_LINE));
        queue_request(make_record(32'h0, DIRECTED_MSG, DIRECTED_SITE, DIRECTED_LINE + 16'd1));
        queue_request(make_record(32'h0, DIRECTED_MSG, DIRECTED_SITE, DIRECTED_LINE));
        queue_request(make_record(32'h0, '0, DIRECTED_SITE, DIRECTED_LINE));
        // All-ones fields land in the last slot.
        req              = make_record('1, '1, '1, '1);
        req.first_param  = '1;
        req.second_param = '1;
        req.timestamp    = '1;
        queue_request(req);
        // Starting at the last slot wraps past the occupied head of the table.
        queue_request(make_record('1, 32'h0000_0C0C, '0, '0));
        queue_request(make_record(32'h0000_03FF, 32'h0000_0C0C, '0, '0));
        queue_request(make_record(32'h8000_03FF, '1, '1, '1));
        queue_request(make_clear());
        queue_request(make_record(32'h0, DIRECTED_MSG, DIRECTED_SITE, DIRECTED_LINE));
        // All-zero payload apart from the message.
        req              = make_record(32'h1234_5678, 32'h1, '0, '0);
        req.first_param  = '0;
        req.second_param = '0;
        req.timestamp    = '0;
        queue_request(req);
        req              = make_clear();
        req.hash_word    = '1;
        req.message_id   = '1;
        req.site_id      = '1;
        req.line_number  = '1;
        queue_request(req);
        queue_request(make_record(32'h5555_AAAA, 32'hAAAA_5555, 32'h5555_AAAA, 16'hA55A));

        // With recording off every record is rejected, while a clear still works.
        write_enabled(1'b0);
        queue_request(make_record(32'h0, DIRECTED_MSG, DIRECTED_SITE, DIRECTED_LINE));
        queue_request(make_record($urandom(), '0, $urandom(), 16'($urandom())));
        queue_request(make_clear());
        queue_request(make_record($urandom(), $urandom() | 32'h1, $urandom(), 16'hFFFF));
        write_enabled(1'b1);

        // Fill every slot in order, then overflow the full table and find a deep entry.
        queue_request(make_clear());
        for (k = 0; k < eehc_pkg::TableDepth; k++) begin
            req = make_record(hash_at(k), $urandom() | 32'h1, $urandom(), 16'($urandom()));
            if (k == eehc_pkg::TableDepth - 300) begin
                deep_key.message = req.message_id;
                deep_key.site    = req.site_id;
                deep_key.line    = req.line_number;
            end
            queue_request(req);
        end
        for (k = 0; k < 3; k++) begin
            queue_request(make_record($urandom(), $urandom() | 32'h1, $urandom(), 16'hFFFF));
        end
        queue_request(make_record(hash_at(5), deep_key.message, deep_key.site, deep_key.line));
        queue_request(make_record($urandom(), '0, $urandom(), 16'($urandom())));
        queue_request(make_clear());

        // Random traffic over several settings of the enable.
        queue_random_phase(320);
        write_enabled(1'b0);
        queue_random_phase(40);
        write_enabled(1'b1);
        queue_random_phase(300);
        queue_random_phase(250);

        drain_results();
        if (expected_results.size() != 0) begin
            report_error($sformatf("%0d expected results never arrived",
                                   expected_results.size()));
        end
        if (error_count == 0) begin
            $display("tb_error_event_hash_counter: clean");
        end else begin
            $display("tb_error_event_hash_counter: errors");
        end
        $finish;
    end

    // Run limit, far above the slowest legal run.
    initial begin : run_limit
        #60_000_000;
        $display("timeout waiting for results");
        $display("tb_error_event_hash_counter: errors");
        $finish;
    end

endmodule

FILE: error_event_hash_counter.f
rtl/core/eehc_pkg.sv
rtl/core/eehc_table.sv
rtl/core/error_event_hash_counter.sv
test/tb_error_event_hash_counter.sv
